/* rtl/thermostat_deadband_alarm_top_defines.svh */
// assertion macros for the thermostat deadband alarm top level
`ifndef THERMOSTAT_DEADBAND_ALARM_TOP_DEFINES_SVH
`define THERMOSTAT_DEADBAND_ALARM_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// checked property, suspended while reset is asserted
`define TDA_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// checked property, active through reset as well
`define TDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define TDA_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define TDA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/tdalm_pkg.sv */
// types and constants of the thermostat deadband alarm
package tdalm_pkg;

	localparam int BAND_BITS     = 8;
	localparam int DELAY_BITS    = 16;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_IDX_BITS  = 8;
	// setpoint limits are held sign-extended to this width
	localparam int LIMIT_BITS    = 16;

	localparam int RST_BAND_WIDTH  = 3;
	localparam int RST_ALARM_DELAY = 60;
	localparam int RST_SP_MIN      = 60;
	localparam int RST_SP_MAX      = 90;
	localparam int RST_SETPOINT    = 75;

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_BAND_WIDTH   = 8'd0,
		REG_ALARM_DELAY  = 8'd1,
		REG_SETPOINT_MIN = 8'd2,
		REG_SETPOINT_MAX = 8'd3
	} cfg_reg_t;

	// item command codes
	localparam logic CMD_READING = 1'b0;
	localparam logic CMD_UPDATE  = 1'b1;

	// configuration in force
	typedef struct packed {
		logic [BAND_BITS-1:0]         band_width;
		logic [DELAY_BITS-1:0]        alarm_delay;
		logic signed [LIMIT_BITS-1:0] setpoint_min;
		logic signed [LIMIT_BITS-1:0] setpoint_max;
	} cfg_t;

	// single-bit flags of one result word
	typedef struct packed {
		logic fan_valid;
		logic fan_on;
		logic alarm_valid;
		logic alarm_on;
		logic update_ack;
		logic update_accepted;
	} res_flags_t;

endpackage

/* rtl/tdalm_ifs.sv */
// handshake channels of the thermostat deadband alarm

// input word: reading or setpoint request
interface tdalm_in_if #(
	parameter int TEMP_BITS = 10,
	parameter int TIME_BITS = 32
);
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic signed [TEMP_BITS-1:0] value;
	logic [TIME_BITS-1:0]        now_seconds;

	modport source (output valid, command, value, now_seconds, input ready);
	modport sink   (input valid, command, value, now_seconds, output ready);
endinterface

// result word
interface tdalm_out_if #(
	parameter int TEMP_BITS = 10
);
	logic                        valid;
	logic                        ready;
	logic                        fan_valid;
	logic                        fan_on;
	logic                        alarm_valid;
	logic                        alarm_on;
	logic                        update_ack;
	logic                        update_accepted;
	logic signed [TEMP_BITS-1:0] current_setpoint;

	modport source (output valid, fan_valid, fan_on, alarm_valid, alarm_on, update_ack,
		update_accepted, current_setpoint, input ready);
	modport sink   (input valid, fan_valid, fan_on, alarm_valid, alarm_on, update_ack,
		update_accepted, current_setpoint, output ready);
endinterface

// configuration write channel
interface tdalm_cfg_if;
	import tdalm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/tdalm_cfg_regs.sv */
// configuration register file
module tdalm_cfg_regs
	import tdalm_pkg::*;
#(
	parameter int TEMP_BITS = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [CFG_IDX_BITS-1:0]  wr_index,
	input  logic [CFG_DATA_BITS-1:0] wr_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;
	logic signed [LIMIT_BITS-1:0] limit_wr;

	// limits arrive as TEMP_BITS two's complement, held sign-extended
	assign limit_wr = LIMIT_BITS'(signed'(wr_data[TEMP_BITS-1:0]));

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_width   <= BAND_BITS'(RST_BAND_WIDTH);
			cfg_q.alarm_delay  <= DELAY_BITS'(RST_ALARM_DELAY);
			cfg_q.setpoint_min <= LIMIT_BITS'(RST_SP_MIN);
			cfg_q.setpoint_max <= LIMIT_BITS'(RST_SP_MAX);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BAND_WIDTH:   cfg_q.band_width   <= wr_data[BAND_BITS-1:0];
				REG_ALARM_DELAY:  cfg_q.alarm_delay  <= wr_data[DELAY_BITS-1:0];
				REG_SETPOINT_MIN: cfg_q.setpoint_min <= limit_wr;
				REG_SETPOINT_MAX: cfg_q.setpoint_max <= limit_wr;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/tdalm_core.sv */
// setpoint, excursion state and per-word decision logic
module tdalm_core
	import tdalm_pkg::*;
#(
	parameter int TEMP_BITS = 10,
	parameter int TIME_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  logic                        en,
	input  logic                        command,
	input  logic signed [TEMP_BITS-1:0] value,
	input  logic [TIME_BITS-1:0]        now_seconds,
	output res_flags_t                  flags,
	output logic signed [TEMP_BITS-1:0] setpoint_next
);

	logic signed [TEMP_BITS-1:0] setpoint_q;
	logic                        exc_active_q;
	logic [TIME_BITS-1:0]        exc_start_q;

	logic signed [TEMP_BITS:0]   diff;
	logic signed [TEMP_BITS:0]   diff_neg;
	logic                        hot;
	logic [TEMP_BITS:0]          dev;
	logic                        out_of_band;
	logic [TIME_BITS-1:0]        elapsed;
	logic signed [LIMIT_BITS-1:0] value_x;
	logic                        in_limits;
	logic                        exc_active_d;
	logic [TIME_BITS-1:0]        exc_start_d;

	// deviation from setpoint, equal counts as cold side
	assign diff        = (TEMP_BITS+1)'(value) - (TEMP_BITS+1)'(setpoint_q);
	assign diff_neg    = -diff;
	assign hot         = diff > 0;
	assign dev         = hot ? diff : diff_neg;
	assign out_of_band = dev > (TEMP_BITS+1)'(cfg.band_width);

	// time since excursion began, wraps with the clock
	assign elapsed = now_seconds - exc_start_q;

	// request limits check
	assign value_x   = LIMIT_BITS'(value);
	assign in_limits = (value_x >= cfg.setpoint_min) && (value_x <= cfg.setpoint_max);

	// decision and next state
	always_comb begin
		flags         = '0;
		setpoint_next = setpoint_q;
		exc_active_d  = exc_active_q;
		exc_start_d   = exc_start_q;
		if (command == CMD_READING) begin
			if (out_of_band) begin
				flags.fan_valid = 1'b1;
				flags.fan_on    = hot;
				if (!exc_active_q) begin
					exc_active_d = 1'b1;
					exc_start_d  = now_seconds;
				end else if (elapsed > TIME_BITS'(cfg.alarm_delay)) begin
					flags.alarm_valid = 1'b1;
					flags.alarm_on    = 1'b1;
				end
			end else begin
				exc_active_d      = 1'b0;
				exc_start_d       = '0;
				flags.alarm_valid = 1'b1;
			end
		end else begin
			flags.update_ack = 1'b1;
			if (in_limits) begin
				setpoint_next         = value;
				flags.update_accepted = 1'b1;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   <= TEMP_BITS'(RST_SETPOINT);
			exc_active_q <= 1'b0;
			exc_start_q  <= '0;
		end else if (en) begin
			setpoint_q   <= setpoint_next;
			exc_active_q <= exc_active_d;
			exc_start_q  <= exc_start_d;
		end
	end

endmodule

/* rtl/thermostat_deadband_alarm_top.sv */
// top level of the thermostat deadband alarm
//
// Words enter on in_ch (valid/ready): command 0 is a temperature reading,
// command 1 a setpoint request; each carries now_seconds. Every word gives
// exactly one result word on out_ch: fan and alarm commands for a reading,
// acknowledge and accept flags for a request, plus the setpoint in force.
// Configuration (band width, alarm delay, setpoint limits) is written on
// cfg; cfg.ready is always high, and writes belong to idle periods.
// An accepted word passes from the input register through the decision
// logic into the result register, which drives out_ch. Throughput: one
// word per cycle while out_ch.ready stays high; the decision logic is
// combinational and the state and result registers load together, so
// words may follow back to back. in_ch.ready drops only while both
// registers hold words and the receiver holds out_ch.ready low; the
// result word then stays on out_ch.
// Reset: arst_n clears both registers' valid flags, loads the register
// defaults (band 3, delay 60 s, limits 60..90) and setpoint 75 with no
// excursion in progress. No result is produced by reset itself.
`include "thermostat_deadband_alarm_top_defines.svh"

module thermostat_deadband_alarm_top
	import tdalm_pkg::*;
#(
	parameter int TEMP_BITS = 10,
	parameter int TIME_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	tdalm_in_if.sink      in_ch,
	tdalm_out_if.source   out_ch,
	tdalm_cfg_if.sink     cfg
);

	cfg_t cfg_cur;

	logic                        valid_s1;
	logic                        command_s1;
	logic signed [TEMP_BITS-1:0] value_s1;
	logic [TIME_BITS-1:0]        now_s1;

	logic                        out_valid_q;
	res_flags_t                  flags_q;
	logic signed [TEMP_BITS-1:0] setpoint_q;

	res_flags_t                  flags_d;
	logic signed [TEMP_BITS-1:0] setpoint_d;

	logic out_free;
	logic adv_s2;
	logic ready_s1;

	// configuration registers
	assign cfg.ready = 1'b1;

	tdalm_cfg_regs #(
		.TEMP_BITS(TEMP_BITS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg.valid),
		.wr_index(cfg.index),
		.wr_data (cfg.data),
		.cfg     (cfg_cur)
	);

	// pipeline flow control
	assign out_free    = !out_valid_q || out_ch.ready;
	assign adv_s2      = valid_s1 && out_free;
	assign ready_s1    = !valid_s1 || out_free;
	assign in_ch.ready = ready_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_ch.valid) begin
			command_s1 <= in_ch.command;
			value_s1   <= in_ch.value;
			now_s1     <= in_ch.now_seconds;
		end
	end

	// decision logic and thermostat state
	tdalm_core #(
		.TEMP_BITS(TEMP_BITS),
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_cur),
		.en           (adv_s2),
		.command      (command_s1),
		.value        (value_s1),
		.now_seconds  (now_s1),
		.flags        (flags_d),
		.setpoint_next(setpoint_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			flags_q    <= flags_d;
			setpoint_q <= setpoint_d;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.fan_valid        = flags_q.fan_valid;
	assign out_ch.fan_on           = flags_q.fan_on;
	assign out_ch.alarm_valid      = flags_q.alarm_valid;
	assign out_ch.alarm_on         = flags_q.alarm_on;
	assign out_ch.update_ack       = flags_q.update_ack;
	assign out_ch.update_accepted  = flags_q.update_accepted;
	assign out_ch.current_setpoint = setpoint_q;

	// checks
	`TDA_ASSERT_RST(a_adv_fills_out, clk, arst_n, adv_s2 |=> out_valid_q,
		"word left input register without reaching result register")
	`TDA_ASSERT_RST(a_request_no_cmds, clk, arst_n,
		(out_valid_q && flags_q.update_ack) |-> !(flags_q.fan_valid || flags_q.alarm_valid),
		"setpoint request result carries a fan or alarm command")
	`TDA_ASSERT_RST(a_accept_needs_ack, clk, arst_n,
		(out_valid_q && flags_q.update_accepted) |-> flags_q.update_ack,
		"update accepted without acknowledge")
	`TDA_ASSERT_RST(a_alarm_on_out_of_band, clk, arst_n,
		(out_valid_q && flags_q.alarm_on) |-> (flags_q.alarm_valid && flags_q.fan_valid),
		"alarm on issued for an in-band reading")

endmodule

/* verif/thermostat_checker.sv */
// checker that predicts and compares every result word of the thermostat block
`timescale 1ns / 100ps

module thermostat_checker
	import tdalm_pkg::*;
#(
	parameter int TEMP_BITS = 10,
	parameter int TIME_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	tdalm_in_if  in_ch,
	tdalm_out_if out_ch,
	tdalm_cfg_if cfg,
	output int   mismatches,
	output int   awaiting
);

	typedef struct packed {
		res_flags_t                  flags;
		logic signed [TEMP_BITS-1:0] setpoint;
	} thermo_result_t;

	// configuration copy
	logic [BAND_BITS-1:0]        band_r;
	logic [DELAY_BITS-1:0]       delay_r;
	logic signed [TEMP_BITS-1:0] sp_lo;
	logic signed [TEMP_BITS-1:0] sp_hi;

	// thermostat state copy
	logic signed [TEMP_BITS-1:0] setpoint_r;
	logic                        excursion_on;
	logic [TIME_BITS-1:0]        excursion_t0;

	thermo_result_t due_results[$];
	int err_cnt;

	task automatic report(input string what, input longint got, input longint want);
		err_cnt++;
		$display("checker: %s mismatch at %0t ns: got %0d, expected %0d", what, $time, got,
			want);
	endtask

	// fan, alarm and setpoint decision for one word
	function automatic thermo_result_t predict_commands(input logic cmd,
		input logic signed [TEMP_BITS-1:0] v, input logic [TIME_BITS-1:0] now);
		thermo_result_t r;
		logic hot;
		int dev;
		logic [TIME_BITS-1:0] elapsed;
		r = '0;
		if (cmd == CMD_READING) begin
			hot = v > setpoint_r;
			dev = hot ? int'(v) - int'(setpoint_r) : int'(setpoint_r) - int'(v);
			if (dev > int'(band_r)) begin
				r.flags.fan_valid = 1'b1;
				r.flags.fan_on = hot;
				if (!excursion_on) begin
					excursion_t0 = now;
					excursion_on = 1'b1;
				end else begin
					// elapsed wraps with the time counter
					elapsed = now - excursion_t0;
					if (elapsed > delay_r) begin
						r.flags.alarm_valid = 1'b1;
						r.flags.alarm_on = 1'b1;
					end
				end
			end else begin
				excursion_on = 1'b0;
				excursion_t0 = '0;
				r.flags.alarm_valid = 1'b1;
				r.flags.alarm_on = 1'b0;
			end
		end else begin
			r.flags.update_ack = 1'b1;
			if (v >= sp_lo && v <= sp_hi) begin
				setpoint_r = v;
				r.flags.update_accepted = 1'b1;
			end
		end
		r.setpoint = setpoint_r;
		return r;
	endfunction

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		thermo_result_t want;
		if (!arst_n) begin
			band_r = BAND_BITS'(RST_BAND_WIDTH);
			delay_r = DELAY_BITS'(RST_ALARM_DELAY);
			sp_lo = TEMP_BITS'(RST_SP_MIN);
			sp_hi = TEMP_BITS'(RST_SP_MAX);
			setpoint_r = TEMP_BITS'(RST_SETPOINT);
			excursion_on = 1'b0;
			excursion_t0 = '0;
			due_results.delete();
			err_cnt = 0;
		end else begin
			// register write, low bits only
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_BAND_WIDTH: band_r = cfg.data[BAND_BITS-1:0];
					REG_ALARM_DELAY: delay_r = cfg.data[DELAY_BITS-1:0];
					REG_SETPOINT_MIN: sp_lo = cfg.data[TEMP_BITS-1:0];
					REG_SETPOINT_MAX: sp_hi = cfg.data[TEMP_BITS-1:0];
					default: ;
				endcase
			end
			// result word against the oldest prediction
			if (out_ch.valid && out_ch.ready) begin
				if (due_results.size() == 0) begin
					report("result with none due", 1, 0);
				end else begin
					want = due_results.pop_front();
					if (out_ch.fan_valid !== want.flags.fan_valid)
						report("fan_valid", out_ch.fan_valid, want.flags.fan_valid);
					if (out_ch.fan_on !== want.flags.fan_on)
						report("fan_on", out_ch.fan_on, want.flags.fan_on);
					if (out_ch.alarm_valid !== want.flags.alarm_valid)
						report("alarm_valid", out_ch.alarm_valid, want.flags.alarm_valid);
					if (out_ch.alarm_on !== want.flags.alarm_on)
						report("alarm_on", out_ch.alarm_on, want.flags.alarm_on);
					if (out_ch.update_ack !== want.flags.update_ack)
						report("update_ack", out_ch.update_ack, want.flags.update_ack);
					if (out_ch.update_accepted !== want.flags.update_accepted)
						report("update_accepted", out_ch.update_accepted,
							want.flags.update_accepted);
					if (out_ch.current_setpoint !== want.setpoint)
						report("current_setpoint", out_ch.current_setpoint, want.setpoint);
				end
			end
			// accepted input word
			if (in_ch.valid && in_ch.ready)
				due_results.push_back(predict_commands(in_ch.command, in_ch.value,
					in_ch.now_seconds));
		end
		mismatches <= err_cnt;
		awaiting <= due_results.size();
	end

endmodule

/* verif/tb.sv */
// testbench top: clock, reset, stimulus and verdict for the thermostat block
`timescale 1ns / 100ps

module tb;
	import tdalm_pkg::*;

	localparam int TEMP_BITS    = 10;
	localparam int TIME_BITS    = 32;
	localparam int PERIOD       = 8;
	localparam int RESET_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 250000;
	localparam int WORD_TARGET  = 1650;
	localparam int PHASE_WORDS  = 150;
	localparam int HOLD_CYCLES  = 300;
	localparam int TEMP_MIN     = -512;
	localparam int TEMP_MAX     = 511;
	// indexes outside the register list
	localparam logic [CFG_IDX_BITS-1:0] REG_NONE_LOW  = 8'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_NONE_HIGH = 8'hFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int mismatches;
	int awaiting;
	int cycles = 0;

	// stimulus view of the block
	int sp_now = RST_SETPOINT;
	int band_now = RST_BAND_WIDTH;
	int delay_now = RST_ALARM_DELAY;
	int lo_now = RST_SP_MIN;
	int hi_now = RST_SP_MAX;
	logic [TIME_BITS-1:0] clock_s = '0;
	bit tx_idle = 1'b1;
	int words_sent = 0;

	tdalm_in_if #(.TEMP_BITS(TEMP_BITS), .TIME_BITS(TIME_BITS)) in_ch ();
	tdalm_out_if #(.TEMP_BITS(TEMP_BITS)) out_ch ();
	tdalm_cfg_if cfg ();

	thermostat_deadband_alarm_top #(.TEMP_BITS(TEMP_BITS), .TIME_BITS(TIME_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	thermostat_checker #(.TEMP_BITS(TEMP_BITS), .TIME_BITS(TIME_BITS)) watch (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg),
		.mismatches(mismatches),
		.awaiting(awaiting)
	);

	always #(PERIOD / 2) clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	function automatic int clamp_temp(input int v);
		return v < TEMP_MIN ? TEMP_MIN : (v > TEMP_MAX ? TEMP_MAX : v);
	endfunction

	// reading outside the band, on the asked side if it fits, else the other side
	function automatic int out_of_band(input bit want_hot);
		int up_base;
		int dn_base;
		int span;
		up_base = sp_now + band_now + 1;
		dn_base = sp_now - band_now - 1;
		if (want_hot && up_base > TEMP_MAX)
			want_hot = 1'b0;
		if (!want_hot && dn_base < TEMP_MIN)
			want_hot = 1'b1;
		span = want_hot ? TEMP_MAX - up_base : dn_base - TEMP_MIN;
		if ($urandom_range(0, 3) != 0 && span > 8)
			span = 8;
		return want_hot ? up_base + int'($urandom_range(0, span))
			: dn_base - int'($urandom_range(0, span));
	endfunction

	function automatic int in_band();
		return clamp_temp(sp_now + int'($urandom_range(0, 2 * band_now)) - band_now);
	endfunction

	// one input word, with a random gap ahead of it
	task automatic send_word(input logic cmd, input int val, input logic [TIME_BITS-1:0] now);
		int gap;
		if (words_sent % 64 == 0)
			tx_idle = ($urandom_range(0, 3) != 0);
		gap = tx_idle ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.value <= val[TEMP_BITS-1:0];
		in_ch.now_seconds <= now;
		do @(posedge clk); while (!in_ch.ready);
		words_sent++;
		if (cmd == CMD_UPDATE && val >= lo_now && val <= hi_now)
			sp_now = val;
	endtask

	task automatic reading(input int val, input logic [TIME_BITS-1:0] now);
		clock_s = now;
		send_word(CMD_READING, val, now);
	endtask

	// setpoint request at, beside or between the limits, or anywhere in range
	task automatic request_word();
		int v;
		case ($urandom_range(0, 4))
			0: v = lo_now;
			1: v = hi_now;
			2: v = $urandom_range(0, 1) ? lo_now - 1 : hi_now + 1;
			3: v = int'($urandom_range(0, 1023)) + TEMP_MIN;
			default: v = (lo_now <= hi_now) ? lo_now + int'($urandom_range(0, hi_now - lo_now))
				: int'($urandom_range(0, 1023)) + TEMP_MIN;
		endcase
		send_word(CMD_UPDATE, clamp_temp(v), clock_s);
	endtask

	// out-of-band run, at times flipping side, usually closed by an in-band reading
	task automatic excursion();
		int n;
		bit hot;
		logic [TIME_BITS-1:0] t0;
		hot = 1'($urandom_range(0, 1));
		n = $urandom_range(2, 7);
		t0 = clock_s + $urandom_range(0, 50);
		reading(out_of_band(hot), t0);
		for (int i = 1; i < n; i++) begin
			if ($urandom_range(0, 4) == 0)
				hot = !hot;
			if ($urandom_range(0, 9) == 0)
				request_word();
			case ($urandom_range(0, 5))
				0: clock_s = t0 + delay_now;
				1: clock_s = t0 + delay_now + 1;
				default: clock_s = clock_s + $urandom_range(0, delay_now / 2 + 2);
			endcase
			reading(out_of_band(hot), clock_s);
		end
		if ($urandom_range(0, 4) != 0)
			reading(in_band(), clock_s + $urandom_range(0, 20));
	endtask

	task automatic random_phase(input int count);
		int target;
		int pick;
		target = words_sent + count;
		// sometimes start just short of the time counter wrap
		if ($urandom_range(0, 2) == 0)
			clock_s = '1 - $urandom_range(0, 200);
		while (words_sent < target) begin
			pick = $urandom_range(0, 19);
			if (pick < 13)
				excursion();
			else if (pick < 16)
				request_word();
			else
				send_word(1'($urandom_range(0, 1)), int'($urandom_range(0, 1023)) + TEMP_MIN,
					$urandom);
		end
	endtask

	// stop sending and wait for every result word
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// new register settings, junk in the unused upper bits
	task automatic set_regs(input int band, input int delay, input int lo, input int hi,
		input bit stray);
		logic [CFG_DATA_BITS-1:0] d;
		drain();
		if (stray) begin
			cfg_write(REG_NONE_LOW, CFG_DATA_BITS'($urandom));
			cfg_write(REG_NONE_HIGH, CFG_DATA_BITS'($urandom));
		end
		d = CFG_DATA_BITS'($urandom);
		d[BAND_BITS-1:0] = band[BAND_BITS-1:0];
		cfg_write(REG_BAND_WIDTH, d);
		cfg_write(REG_ALARM_DELAY, delay[DELAY_BITS-1:0]);
		d = CFG_DATA_BITS'($urandom);
		d[TEMP_BITS-1:0] = lo[TEMP_BITS-1:0];
		cfg_write(REG_SETPOINT_MIN, d);
		d = CFG_DATA_BITS'($urandom);
		d[TEMP_BITS-1:0] = hi[TEMP_BITS-1:0];
		cfg_write(REG_SETPOINT_MAX, d);
		cfg.valid <= 1'b0;
		band_now = band;
		delay_now = delay;
		lo_now = lo;
		hi_now = hi;
	endtask

	// result side: random stalls, two long hold-offs
	initial begin
		int gap;
		int taken;
		bit rx_idle;
		taken = 0;
		rx_idle = 1'b1;
		out_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (taken == 400 || taken == 1100) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (taken % 50 == 0)
				rx_idle = ($urandom_range(0, 3) != 0);
			gap = rx_idle ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
			taken++;
		end
	end

	// stimulus and verdict
	initial begin
		int band;
		int delay;
		int lo;
		int hi;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_READING;
		in_ch.value = '0;
		in_ch.now_seconds = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_BAND_WIDTH;
		cfg.data = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: band 3, delay 60, limits 60..90, setpoint 75
		reading(75, 100);
		reading(78, 101);
		reading(72, 102);
		reading(79, 1000);
		reading(80, 1060);
		reading(70, 1061);
		reading(75, 1062);
		reading(TEMP_MAX, 32'hFFFF_FFF0);
		reading(TEMP_MIN, 32'h0000_002C);
		reading(TEMP_MIN, 32'h0000_002D);
		reading(76, 32'hFFFF_FFFF);
		send_word(CMD_UPDATE, 60, clock_s);
		send_word(CMD_UPDATE, 59, clock_s);
		send_word(CMD_UPDATE, 90, clock_s);
		send_word(CMD_UPDATE, 91, clock_s);
		send_word(CMD_UPDATE, TEMP_MIN, clock_s);
		send_word(CMD_UPDATE, TEMP_MAX, clock_s);
		send_word(CMD_UPDATE, 75, clock_s);
		reading(79, 32'h8000_0000);
		reading(71, 32'h7FFF_FFFF);
		reading(75, 5);

		// widest limits, no band, no delay
		set_regs(0, 0, TEMP_MIN, TEMP_MAX, 1'b1);
		random_phase(PHASE_WORDS);
		// widest band and delay, inverted limits
		set_regs(255, 65535, TEMP_MAX, TEMP_MIN, 1'b0);
		random_phase(PHASE_WORDS);

		while (words_sent < WORD_TARGET) begin
			band = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
			delay = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
				: $urandom_range(0, 150);
			lo = int'($urandom_range(0, 1023)) + TEMP_MIN;
			hi = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 1023)) + TEMP_MIN
				: clamp_temp(lo + int'($urandom_range(0, 200)));
			set_regs(band, delay, lo, hi, $urandom_range(0, 3) == 0);
			random_phase(PHASE_WORDS);
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/tdalm_pkg.sv
rtl/tdalm_ifs.sv
rtl/tdalm_cfg_regs.sv
rtl/tdalm_core.sv
rtl/thermostat_deadband_alarm_top.sv
verif/thermostat_checker.sv
verif/tb.sv
